FILE: hw/rtl/lphm_pkg.sv
`default_nettype none

package lphm_pkg;

  // Default slot count; must be a power of two.
  localparam int unsigned LPHM_SLOTS = 1024;

  localparam int KEY_W    = 64;
  localparam int TIME_W   = 64;
  localparam int KIND_W   = 8;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 11;

  // Inbound word: fp_low, fp_high, mod_time, entry_kind (200 bits, whole bytes).
  localparam int S_TDATA_W = 2 * KEY_W + TIME_W + KIND_W;
  // Outbound word: found_time, found_kind, occupancy, padded to 88 bits.
  localparam int M_TDATA_W = 88;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 3'd0,
    ST_MISSING  = 3'd1,
    ST_INSERTED = 3'd2,
    ST_UPDATED  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // splitmix64 finalizer constants.
  localparam logic [63:0] HASH_ADD = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] HASH_M1  = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] HASH_M2  = 64'h94d0_49bb_1331_11eb;
  localparam int          HASH_S1  = 30;
  localparam int          HASH_S2  = 27;
  localparam int          HASH_S3  = 31;

endpackage

`default_nettype wire

FILE: hw/rtl/linear_probe_hash_map.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser = action; s_tdata = fp_low, fp_high, mod_time,
//                                   entry_kind
// m_*       out  m_tvalid/m_tready  m_tuser = status; m_tdata = found_time, found_kind,
//                                   occupancy
//
// Once an item is accepted, four steps (S_MUL1, S_SUM1, S_MUL2, S_SUM2) run the splitmix64
// hash through one shared bank of 32x32 partial-product multipliers, then the slot memory's
// single read port visits one slot per cycle, P slots in all, where P is the number of slots
// probed (1 to SLOTS), and S_DONE hands the result to the output register, after which the
// block can take the next word. After reset the block sweeps the whole slot memory, clearing
// every valid mark, and holds s_tready low meanwhile. A result waiting in the output register
// does not block the next item; only a second finished result waits for m_tready.
`default_nettype none

module linear_probe_hash_map #(
  parameter int unsigned SLOTS = lphm_pkg::LPHM_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [63:0] fp_low, [127:64] fp_high, [191:128] mod_time, [199:192] entry_kind
  input  logic [lphm_pkg::S_TDATA_W-1:0] s_tdata,
  // [0] action: 0 lookup, 1 insert or update
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [63:0] found_time, [71:64] found_kind, [82:72] occupancy, [87:83] zero
  output logic [lphm_pkg::M_TDATA_W-1:0] m_tdata,
  // [2:0] status
  output logic [lphm_pkg::STATUS_W-1:0]  m_tuser
);

  import lphm_pkg::*;

  localparam int AW        = $clog2(SLOTS);
  localparam int CNT_W     = AW + 1;
  localparam int OCC_EXT_W = (CNT_W > OCC_W) ? CNT_W : OCC_W;
  localparam int M_PAD_W   = M_TDATA_W - (TIME_W + KIND_W + OCC_W);

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key_high;
    logic [KEY_W-1:0]  key_low;
    logic [TIME_W-1:0] stamp;
    logic [KIND_W-1:0] kind;
  } slot_t;

  // Clearing sweep and idle, then the hash steps, the probe walk and the output handoff.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL1,
    S_SUM1,
    S_MUL2,
    S_SUM2,
    S_CHECK,
    S_DONE
  } state_t;

  state_t            state;

  // Latched request.
  logic              req_insert;
  logic [KEY_W-1:0]  req_key_low;
  logic [KEY_W-1:0]  req_key_high;
  logic [TIME_W-1:0] req_time;
  logic [KIND_W-1:0] req_kind;

  // Hash datapath: the value being mixed and its three partial products.
  logic [63:0]       mix_x;
  logic [63:0]       pp_lo;
  logic [31:0]       pp_mid_a;
  logic [31:0]       pp_mid_b;

  // Probe walk and clearing sweep.
  logic [AW-1:0]     pos;
  logic [AW-1:0]     probe_cnt;
  logic [AW-1:0]     clr_addr;
  logic [CNT_W-1:0]  used_count;

  // Finished result, waiting for the output register.
  status_t           res_status;
  logic [TIME_W-1:0] res_time;
  logic [KIND_W-1:0] res_kind;

  // Output register.
  status_t           out_status;
  logic [TIME_W-1:0] out_time;
  logic [KIND_W-1:0] out_kind;
  logic [OCC_W-1:0]  out_occ;

  // Slot memory with one write and one registered read port.
  slot_t             slot_mem [SLOTS];
  slot_t             rd_entry;
  slot_t             wr_entry;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic              wr_en;

  // Combinational helpers.
  logic [63:0]       add_v;
  logic [63:0]       mix_in;
  logic [63:0]       mult_const;
  logic [63:0]       prod;
  logic [63:0]       mix_mid;
  logic [63:0]       mix_out;
  logic [AW-1:0]     home;
  logic [AW-1:0]     pos_inc;
  logic              key_hit;
  logic              last_probe;
  logic              store_hit;
  logic [OCC_EXT_W-1:0] occ_ext;

  always_comb begin
    // First step of the mixer: offset and the first xor-shift.
    add_v      = s_tdata[KEY_W-1:0] + HASH_ADD;
    mix_in     = add_v ^ (add_v >> HASH_S1);
    // Low 64 bits of a 64x64 product from three 32x32 partial products.
    mult_const = (state == S_MUL1) ? HASH_M1 : HASH_M2;
    prod       = pp_lo + {pp_mid_a + pp_mid_b, 32'b0};
    mix_mid    = prod ^ (prod >> HASH_S2);
    mix_out    = prod ^ (prod >> HASH_S3);
    home       = mix_out[AW-1:0];
    pos_inc    = pos + AW'(1);
    key_hit    = (rd_entry.key_low == req_key_low) && (rd_entry.key_high == req_key_high);
    last_probe = (probe_cnt == '1);
    store_hit  = (state == S_CHECK) && req_insert && (!rd_entry.valid || key_hit);
    occ_ext    = OCC_EXT_W'(used_count);
  end

  // The walk reads the home slot as the hash completes, then the next slot each cycle it
  // keeps going. A write only ends a walk, and the next item's first read comes only after
  // its hash steps, so no read ever meets a pending write to the same slot.
  always_comb begin
    rd_addr  = (state == S_SUM2) ? home : pos_inc;
    wr_en    = 1'b0;
    wr_addr  = pos;
    wr_entry = '{valid: 1'b1, key_high: req_key_high, key_low: req_key_low,
                 stamp: req_time, kind: req_kind};
    if (state == S_CLEAR) begin
      wr_en    = 1'b1;
      wr_addr  = clr_addr;
      wr_entry = '0;
    end else if (store_hit) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_entry;
    end
    rd_entry <= slot_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      used_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // In S_DONE the handoff below decides m_tvalid on its own.
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            req_insert   <= s_tuser;
            req_key_low  <= s_tdata[KEY_W-1:0];
            req_key_high <= s_tdata[2*KEY_W-1:KEY_W];
            req_time     <= s_tdata[2*KEY_W+TIME_W-1:2*KEY_W];
            req_kind     <= s_tdata[S_TDATA_W-1:2*KEY_W+TIME_W];
            mix_x        <= mix_in;
            state        <= S_MUL1;
          end
        end
        S_MUL1, S_MUL2: begin
          pp_lo    <= 64'(mix_x[31:0]) * 64'(mult_const[31:0]);
          pp_mid_a <= mix_x[31:0] * mult_const[63:32];
          pp_mid_b <= mix_x[63:32] * mult_const[31:0];
          state    <= (state == S_MUL1) ? S_SUM1 : S_SUM2;
        end
        S_SUM1: begin
          mix_x <= mix_mid;
          state <= S_MUL2;
        end
        S_SUM2: begin
          pos       <= home;
          probe_cnt <= '0;
          state     <= S_CHECK;
        end
        S_CHECK: begin
          if (!rd_entry.valid) begin
            // Empty slot ends the walk: insert here, or the key is absent.
            res_status <= req_insert ? ST_INSERTED : ST_MISSING;
            res_time   <= '0;
            res_kind   <= '0;
            if (req_insert) begin
              used_count <= used_count + CNT_W'(1);
            end
            state <= S_DONE;
          end else if (key_hit) begin
            res_status <= req_insert ? ST_UPDATED : ST_FOUND;
            res_time   <= req_insert ? '0 : rd_entry.stamp;
            res_kind   <= req_insert ? '0 : rd_entry.kind;
            state      <= S_DONE;
          end else if (last_probe) begin
            // Every slot is taken by some other key.
            res_status <= req_insert ? ST_FULL : ST_MISSING;
            res_time   <= '0;
            res_kind   <= '0;
            state      <= S_DONE;
          end else begin
            pos       <= pos_inc;
            probe_cnt <= probe_cnt + AW'(1);
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_status <= res_status;
            out_time   <= res_time;
            out_kind   <= res_kind;
            out_occ    <= occ_ext[OCC_W-1:0];
            state      <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {{M_PAD_W{1'b0}}, out_occ, out_kind, out_time};
  assign m_tuser  = out_status;

endmodule

`default_nettype wire

FILE: hw/rtl/lphm_checker.sv
`default_nettype none

module lphm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [lphm_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [lphm_pkg::STATUS_W-1:0]  m_tuser
);

  import lphm_pkg::*;

  // Reset starts the clearing sweep, so no word is taken right after it.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("s_tready high right after reset");

  // One item at a time: taking a word drops s_tready for the hash and walk.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("s_tready stayed high after a word was taken");

  // Only a successful lookup carries stored data.
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_FOUND)) |-> (m_tdata[TIME_W+KIND_W-1:0] == '0))
    else $error("nonzero time or kind on a result that is not a hit");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result word changed");

endmodule

bind linear_probe_hash_map lphm_checker u_lphm_checker (.*);

`default_nettype wire
